// ===== rtl/hmthq_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants for the heightmap triangle height query block.
// No dependencies; used by heightmap_triangle_height_query.
package hmthq_pkg;

  // Parameter defaults
  localparam int MaxGridSideDef  = 256;
  localparam int FractionBitsDef = 16;

  // Register indexes (paddr[2])
  localparam logic RegGridSide  = 1'b0;
  localparam logic RegGridScale = 1'b1;

  // Request kinds (tuser)
  localparam logic ModeWrite = 1'b0;
  localparam logic ModeQuery = 1'b1;

  // Register reset values
  localparam logic [8:0]  GridSideRst  = 9'd256;
  localparam logic [31:0] GridScaleRst = 32'd65536;

endpackage

// ===== rtl/heightmap_triangle_height_query.sv =====
`timescale 1ns / 1ps
// Heightmap triangle height query: height store, grid mapping and barycentric interpolation.
// Depends on hmthq_pkg.
//
// The block takes one request per cycle, writes and queries alike, with no
// bubbles while the output side keeps taking results. A write (tuser = 0)
// stores a height at a row-major index and gives no result. A query
// (tuser = 1) gives one result. The flow goes through eight register
// stages: grid-space products, clamping, cell and fraction split, vertex
// address and weight selection, height read, weight products, sum, and
// rounding into the output register. The three heights of a query are
// read in the same cycle from two copies of the height memory, one with
// two read ports and one with one. Both copies take every in-grid write.
// Writes reach the memory at the same stage as query reads, so queries see
// the writes accepted before them. The height store has no reset; a query
// must touch only entries written since reset. The user must write
// configuration only while no request is in flight; this is not enforced.
module heightmap_triangle_height_query #(
  parameter int MAX_GRID_SIDE = hmthq_pkg::MaxGridSideDef,
  parameter int FRACTION_BITS = hmthq_pkg::FractionBitsDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // APB-style configuration port
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  // Request stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [15:0] height_index, [47:16] height_value, [79:48] query_x, [111:80] query_z
  input  logic [111:0] s_axis_tdata,
  // [0] mode
  input  logic         s_axis_tuser,
  // Result stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [31:0] result_height
  output logic [31:0]  m_axis_tdata
);

  localparam int F     = FRACTION_BITS;
  localparam int SW    = $clog2(MAX_GRID_SIDE);
  localparam int SIDEW = $clog2(MAX_GRID_SIDE + 1);
  localparam int Depth = MAX_GRID_SIDE * MAX_GRID_SIDE;
  localparam int AW    = $clog2(Depth);
  localparam int GW    = SW + F;
  localparam int TW    = F + 1;
  localparam int PW    = 65;
  localparam int PRW   = 34 + F;
  localparam int SUMW  = PRW + 2;
  localparam int RW    = SUMW - F;

  localparam logic [TW-1:0]   OneQ       = {1'b1, {F{1'b0}}};
  localparam logic [SUMW-1:0] RoundBias  = {{(SUMW-F){1'b0}}, 1'b1, {(F-1){1'b0}}};

  // ---------------------------------------------------------------- config
  logic [8:0]  cfg_side_q;
  logic [31:0] cfg_scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_side_q  <= hmthq_pkg::GridSideRst;
      cfg_scale_q <= hmthq_pkg::GridScaleRst;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        hmthq_pkg::RegGridSide:  cfg_side_q  <= pwdata[8:0];
        hmthq_pkg::RegGridScale: cfg_scale_q <= pwdata;
      endcase
    end
  end

  assign pready = 1'b1;

  always_comb begin
    unique case (paddr[2])
      hmthq_pkg::RegGridSide:  prdata = {23'd0, cfg_side_q};
      hmthq_pkg::RegGridScale: prdata = cfg_scale_q;
    endcase
  end

  logic [SIDEW-1:0]   side_eff;
  logic [SW-1:0]      side_m1;
  logic [SW-1:0]      side_m2;
  logic [2*SIDEW-1:0] side_sq;

  always_comb begin
    if (cfg_side_q < 9'd2) begin
      side_eff = SIDEW'(2);
    end else if (32'(cfg_side_q) > MAX_GRID_SIDE) begin
      side_eff = SIDEW'(MAX_GRID_SIDE);
    end else begin
      side_eff = SIDEW'(cfg_side_q);
    end
    side_m1 = SW'(side_eff - SIDEW'(1));
    side_m2 = SW'(side_eff - SIDEW'(2));
    side_sq = (2*SIDEW)'(side_eff) * (2*SIDEW)'(side_eff);
  end

  // ---------------------------------------------------------- flow control
  logic [8:1] vld_q;
  logic [8:1] rdy;

  always_comb begin
    rdy[8] = !vld_q[8] || m_axis_tready;
    for (int k = 7; k >= 1; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  assign s_axis_tready = rdy[1];

  logic q4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[1]) vld_q[1] <= s_axis_tvalid;
      for (int k = 2; k <= 8; k++) begin
        if (rdy[k] && k != 5) vld_q[k] <= vld_q[k-1];
      end
      // writes leave the pipe at the memory stage
      if (rdy[5]) vld_q[5] <= vld_q[4] && (q4_q == hmthq_pkg::ModeQuery);
    end
  end

  // ------------------------------------------------- stage 1: scale product
  logic                 q1_q, wok1_q;
  logic [AW-1:0]        wa1_q;
  logic [31:0]          hv1_q;
  logic signed [PW-1:0] px1_q, pz1_q;
  logic signed [PW-1:0] px1_d, pz1_d;
  logic                 wok1_d;

  always_comb begin
    px1_d  = $signed(s_axis_tdata[79:48]) * $signed({1'b0, cfg_scale_q});
    pz1_d  = $signed(s_axis_tdata[111:80]) * $signed({1'b0, cfg_scale_q});
    wok1_d = 32'(s_axis_tdata[15:0]) < 32'(side_sq);
  end

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      q1_q   <= s_axis_tuser;
      wok1_q <= wok1_d;
      wa1_q  <= AW'(s_axis_tdata[15:0]);
      hv1_q  <= s_axis_tdata[47:16];
      px1_q  <= px1_d;
      pz1_q  <= pz1_d;
    end
  end

  // ------------------------------------------------ stage 2: offset, clamp
  function automatic logic [GW-1:0] to_grid(input logic signed [PW-1:0] prod,
                                            input logic signed [PW-1:0] half,
                                            input logic [SW-1:0]        sm1);
    logic signed [PW-1:0] sh;
    sh = prod + half;
    if (prod < -half) begin
      return '0;
    end else if (prod >= half) begin
      return {sm1, {F{1'b0}}};
    end else begin
      return sh[F+GW-1:F];
    end
  endfunction

  logic                 q2_q, wok2_q;
  logic [AW-1:0]        wa2_q;
  logic [31:0]          hv2_q;
  logic [GW-1:0]        gx2_q, gz2_q;
  logic signed [PW-1:0] half;

  assign half = $signed(PW'(side_m1) << (2*F-1));

  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      q2_q   <= q1_q;
      wok2_q <= wok1_q;
      wa2_q  <= wa1_q;
      hv2_q  <= hv1_q;
      gx2_q  <= to_grid(px1_q, half, side_m1);
      gz2_q  <= to_grid(pz1_q, half, side_m1);
    end
  end

  // ------------------------------------------- stage 3: cell and fraction
  logic          q3_q, wok3_q, up3_q;
  logic [AW-1:0] wa3_q;
  logic [31:0]   hv3_q;
  logic [SW-1:0] cx3_q, cz3_q;
  logic [TW-1:0] tx3_q, tz3_q;
  logic [SW-1:0] cx3_d, cz3_d;
  logic [TW-1:0] tx3_d, tz3_d;

  always_comb begin
    // top edge: cell clamps to side-2, fraction is one
    if (gx2_q[GW-1:F] > side_m2) begin
      cx3_d = side_m2;
      tx3_d = OneQ;
    end else begin
      cx3_d = gx2_q[GW-1:F];
      tx3_d = {1'b0, gx2_q[F-1:0]};
    end
    if (gz2_q[GW-1:F] > side_m2) begin
      cz3_d = side_m2;
      tz3_d = OneQ;
    end else begin
      cz3_d = gz2_q[GW-1:F];
      tz3_d = {1'b0, gz2_q[F-1:0]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      q3_q   <= q2_q;
      wok3_q <= wok2_q;
      wa3_q  <= wa2_q;
      hv3_q  <= hv2_q;
      cx3_q  <= cx3_d;
      cz3_q  <= cz3_d;
      tx3_q  <= tx3_d;
      tz3_q  <= tz3_d;
      up3_q  <= tz3_d >= tx3_d;
    end
  end

  // ---------------------------------------- stage 4: addresses and weights
  logic          wok4_q;
  logic [AW-1:0] wa4_q;
  logic [31:0]   hv4_q;
  logic [AW-1:0] i0_4_q, i1_4_q, i2_4_q;
  logic [TW-1:0] w0_4_q, w1_4_q, w2_4_q;
  logic [AW-1:0] v00, v01;
  logic [AW-1:0] i1_4_d, i2_4_d;
  logic [TW-1:0] w0_4_d, w1_4_d, w2_4_d;

  always_comb begin
    v00 = AW'(cz3_q) * AW'(side_eff) + AW'(cx3_q);
    v01 = v00 + AW'(side_eff);
    if (up3_q) begin
      i1_4_d = v01;
      i2_4_d = v01 + AW'(1);
      w0_4_d = OneQ - tz3_q;
      w1_4_d = tz3_q - tx3_q;
      w2_4_d = tx3_q;
    end else begin
      i1_4_d = v01 + AW'(1);
      i2_4_d = v00 + AW'(1);
      w0_4_d = OneQ - tx3_q;
      w1_4_d = tz3_q;
      w2_4_d = tx3_q - tz3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[4]) begin
      q4_q   <= q3_q;
      wok4_q <= wok3_q;
      wa4_q  <= wa3_q;
      hv4_q  <= hv3_q;
      i0_4_q <= v00;
      i1_4_q <= i1_4_d;
      i2_4_q <= i2_4_d;
      w0_4_q <= w0_4_d;
      w1_4_q <= w1_4_d;
      w2_4_q <= w2_4_d;
    end
  end

  // ------------------------------------------------ stage 5: height memory
  logic [31:0]   mem_a_q [Depth];
  logic [31:0]   mem_b_q [Depth];
  logic [31:0]   h0_5_q, h1_5_q, h2_5_q;
  logic [TW-1:0] w0_5_q, w1_5_q, w2_5_q;

  always_ff @(posedge clk_i) begin
    if (rdy[5]) begin
      if (vld_q[4] && (q4_q == hmthq_pkg::ModeWrite) && wok4_q) begin
        mem_a_q[wa4_q] <= hv4_q;
        mem_b_q[wa4_q] <= hv4_q;
      end
      h0_5_q <= mem_a_q[i0_4_q];
      h1_5_q <= mem_a_q[i1_4_q];
      h2_5_q <= mem_b_q[i2_4_q];
      w0_5_q <= w0_4_q;
      w1_5_q <= w1_4_q;
      w2_5_q <= w2_4_q;
    end
  end

  // ----------------------------------------------- stage 6: weight products
  logic signed [PRW-1:0] p0_6_q, p1_6_q, p2_6_q;

  always_ff @(posedge clk_i) begin
    if (rdy[6]) begin
      p0_6_q <= $signed(h0_5_q) * $signed({1'b0, w0_5_q});
      p1_6_q <= $signed(h1_5_q) * $signed({1'b0, w1_5_q});
      p2_6_q <= $signed(h2_5_q) * $signed({1'b0, w2_5_q});
    end
  end

  // ---------------------------------------------------------- stage 7: sum
  logic signed [SUMW-1:0] sum7_q;

  always_ff @(posedge clk_i) begin
    if (rdy[7]) begin
      sum7_q <= SUMW'(p0_6_q) + SUMW'(p1_6_q) + SUMW'(p2_6_q);
    end
  end

  // ------------------------------------------- stage 8: round and saturate
  logic [SUMW-1:0] rnd8;
  logic [RW-1:0]   r8;
  logic [31:0]     res8_d;
  logic [31:0]     res8_q;

  always_comb begin
    rnd8 = sum7_q + RoundBias;
    r8   = rnd8[SUMW-1:F];
    if (r8[RW-1:31] == {(RW-31){r8[31]}}) begin
      res8_d = r8[31:0];
    end else if (r8[RW-1]) begin
      res8_d = 32'h8000_0000;
    end else begin
      res8_d = 32'h7fff_ffff;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[8]) begin
      res8_q <= res8_d;
    end
  end

  assign m_axis_tvalid = vld_q[8];
  assign m_axis_tdata  = res8_q;

  // ------------------------------------------------------------ assertions
  a_stall_from_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("intake stalled without output backpressure");

  a_cell_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[3] && q3_q == hmthq_pkg::ModeQuery) |->
      (cx3_q <= side_m2 && cz3_q <= side_m2 && tx3_q <= OneQ && tz3_q <= OneQ))
    else $error("cell index or fraction out of range");

  a_weights_sum_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[4] && q4_q == hmthq_pkg::ModeQuery) |->
      ((TW+2)'(w0_4_q) + (TW+2)'(w1_4_q) + (TW+2)'(w2_4_q) == (TW+2)'(OneQ)))
    else $error("barycentric weights do not sum to one");

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// Testbench for heightmap_triangle_height_query: a directed table, then random phases
// over several grid settings, each result checked against a typed value or an in-bench height predictor.
// Depends on hmthq_pkg and the heightmap_triangle_height_query RTL.
module testbench;

  localparam int FracBits = hmthq_pkg::FractionBitsDef;
  localparam int MaxSide = hmthq_pkg::MaxGridSideDef;
  localparam int StoreDepth = MaxSide * MaxSide;
  localparam int Latency = 8;
  localparam int SettleCycles = 4 * Latency;
  localparam int HoldOffCycles = 400;
  localparam int ItemsPerPhase = 165;
  localparam longint CycleLimit = 500000;
  localparam longint OneQ = 64'sd1 << FracBits;
  localparam longint SatMax = 64'sd2147483647;
  localparam longint SatMin = -64'sd2147483648;

  typedef struct {
    int unsigned i0, i1, i2;
    longint w0, w1, w2;
  } triangle_t;

  typedef struct {
    logic        mode;
    logic [15:0] idx;
    logic [31:0] val;
    logic [31:0] qx;
    logic [31:0] qz;
    bit          typed;
    logic [31:0] result;
  } dir_row_t;

  logic         clk_i;
  logic         rst_ni = 1'b0;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [2:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  // [15:0] height_index, [47:16] height_value, [79:48] query_x, [111:80] query_z
  logic [111:0] s_axis_tdata = '0;
  // [0] mode
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b1;
  // [31:0] result_height
  logic [31:0]  m_axis_tdata;

  logic [8:0]         cfg_side = hmthq_pkg::GridSideRst;
  logic [31:0]        cfg_scale = hmthq_pkg::GridScaleRst;
  logic signed [31:0] height_mem [StoreDepth];
  bit                 written [StoreDepth];
  logic [31:0]        expected_heights [$];
  logic [31:0]        expected_now;
  int                 fail_count = 0;
  int                 sent_count = 0;
  int                 send_idle_pct = 0;
  int                 recv_stall_pct = 0;
  bit                 hold_armed = 1'b0;
  bit                 hold_done = 1'b0;
  longint             cycles = 0;
  dir_row_t           dir_rows [23];

  heightmap_triangle_height_query dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------- predictor ----------------

  function automatic int unsigned side_in_use();
    if (cfg_side < 2) return 2;
    if (cfg_side > MaxSide) return MaxSide;
    return int'(cfg_side);
  endfunction

  // Grid-space position in Q.F, clamped to [0, side-1]
  function automatic longint grid_pos(input logic [31:0] coord, input int unsigned side);
    longint prod;
    longint span;
    longint half;
    prod = longint'(signed'(coord)) * longint'({32'd0, cfg_scale});
    span = longint'(side - 1) << (2 * FracBits);
    half = longint'(side - 1) << (2 * FracBits - 1);
    if (prod < -half) return 0;
    if (prod >= span - half) return longint'(side - 1) << FracBits;
    return (prod + half) >>> FracBits;
  endfunction

  function automatic triangle_t triangle_of(input logic [31:0] qx, input logic [31:0] qz);
    triangle_t t;
    int unsigned side;
    int unsigned cx, cz, v00, v01;
    longint gx, gz, tx, tz;
    side = side_in_use();
    gx = grid_pos(qx, side);
    gz = grid_pos(qz, side);
    cx = int'(gx >>> FracBits);
    cz = int'(gz >>> FracBits);
    if (cx > side - 2) cx = side - 2;
    if (cz > side - 2) cz = side - 2;
    tx = gx - (longint'(cx) << FracBits);
    tz = gz - (longint'(cz) << FracBits);
    v00 = cz * side + cx;
    v01 = v00 + side;
    if (tz >= tx) begin
      t.i0 = v00;
      t.i1 = v01;
      t.i2 = v01 + 1;
      t.w0 = OneQ - tz;
      t.w1 = tz - tx;
      t.w2 = tx;
    end else begin
      t.i0 = v00;
      t.i1 = v01 + 1;
      t.i2 = v00 + 1;
      t.w0 = OneQ - tx;
      t.w1 = tz;
      t.w2 = tx - tz;
    end
    return t;
  endfunction

  function automatic logic [31:0] interpolate(input triangle_t t);
    longint acc;
    acc = longint'(height_mem[t.i0]) * t.w0 + longint'(height_mem[t.i1]) * t.w1
        + longint'(height_mem[t.i2]) * t.w2;
    acc = (acc + (OneQ >>> 1)) >>> FracBits;
    if (acc > SatMax) acc = SatMax;
    if (acc < SatMin) acc = SatMin;
    return acc[31:0];
  endfunction

  // ---------------- stimulus ----------------

  function automatic logic [31:0] pick_height();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_coord(input int unsigned side);
    logic [63:0] reach;
    logic [63:0] spread;
    longint pos;
    case ($urandom_range(0, 9))
      0, 1: return $urandom;
      2: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default: begin
        if (cfg_scale == 0) return $urandom;
        // half of the world extent in coordinate units, with some margin past the edge
        reach = (64'(side - 1) << (2 * FracBits - 1)) / cfg_scale + 1;
        if (reach > 64'd2147483647) reach = 64'd2147483647;
        spread = reach * 2 + reach / 4 + 1;
        pos = longint'({$urandom, $urandom} % spread) - longint'(reach + reach / 8);
        if ($urandom_range(0, 3) == 0) pos[13:0] = '0;
        if (pos > SatMax) pos = SatMax;
        if (pos < SatMin) pos = SatMin;
        return pos[31:0];
      end
    endcase
  endfunction

  task automatic drive_request(input logic mode, input logic [15:0] idx,
                               input logic [31:0] val, input logic [31:0] qx,
                               input logic [31:0] qz);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {qz, qx, val, idx};
    do @(posedge clk_i); while (!s_axis_tready);
    sent_count++;
  endtask

  task automatic write_height(input logic [15:0] idx, input logic [31:0] val);
    int unsigned side;
    side = side_in_use();
    if (idx < side * side) begin
      height_mem[idx] = val;
      written[idx] = 1'b1;
    end
    drive_request(hmthq_pkg::ModeWrite, idx, val, $urandom, $urandom);
  endtask

  // Corners never written are filled first, so no query reads an undefined height.
  task automatic query_height(input logic [31:0] qx, input logic [31:0] qz,
                              input bit typed, input logic [31:0] typed_result);
    triangle_t t;
    t = triangle_of(qx, qz);
    if (!written[t.i0]) write_height(16'(t.i0), pick_height());
    if (!written[t.i1]) write_height(16'(t.i1), pick_height());
    if (!written[t.i2]) write_height(16'(t.i2), pick_height());
    expected_heights.push_back(typed ? typed_result : interpolate(t));
    drive_request(hmthq_pkg::ModeQuery, 16'($urandom), $urandom, qx, qz);
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (expected_heights.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_register(input logic reg_sel, input logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (reg_sel == hmthq_pkg::RegGridSide) cfg_side = value[8:0];
    else cfg_scale = value;
  endtask

  task automatic run_phase(input logic [8:0] side_val, input logic [31:0] scale_val,
                           input int idle_mode, input bit pressure);
    int unsigned side;
    logic [15:0] idx;
    int stop_at;
    case (idle_mode)
      1: begin send_idle_pct = 46; recv_stall_pct = 0; end
      2: begin send_idle_pct = 0; recv_stall_pct = 46; end
      3: begin send_idle_pct = 24; recv_stall_pct = 24; end
      default: begin send_idle_pct = 0; recv_stall_pct = 0; end
    endcase
    write_register(hmthq_pkg::RegGridSide, {23'd0, side_val});
    write_register(hmthq_pkg::RegGridScale, scale_val);
    hold_armed = pressure;
    side = side_in_use();
    stop_at = sent_count + ItemsPerPhase;
    while (sent_count < stop_at) begin
      if ($urandom_range(0, 99) < 45) begin
        if (side < MaxSide && $urandom_range(0, 7) == 0)
          idx = 16'($urandom_range(side * side, StoreDepth - 1));
        else
          idx = 16'($urandom_range(0, side * side - 1));
        write_height(idx, pick_height());
      end else begin
        query_height(pick_coord(side), pick_coord(side), 1'b0, '0);
      end
    end
    settle();
  endtask

  // ---------------- result side ----------------

  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_armed && !hold_done) begin
        hold_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk_i);
      end
      m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_heights.size() == 0) begin
        $error("result_height: expected none, got %h", m_axis_tdata);
        fail_count++;
      end else begin
        expected_now = expected_heights.pop_front();
        if (m_axis_tdata !== expected_now) begin
          $error("result_height: expected %h, got %h", expected_now, m_axis_tdata);
          fail_count++;
        end
      end
    end
  end

  // ---------------- main sequence ----------------

  initial begin
    // corners at the far edges, grid center, then interior triangles
    dir_rows = '{
      '{hmthq_pkg::ModeWrite, 16'd0,     32'h7FFF_FFFF, 32'h0, 32'h0, 1'b0, 32'h0},
      '{hmthq_pkg::ModeWrite, 16'd256,   32'h7FFF_FFFF, 32'h0, 32'h0, 1'b0, 32'h0},
      '{hmthq_pkg::ModeWrite, 16'd257,   32'h8000_0000, 32'h0, 32'h0, 1'b0, 32'h0},
      '{hmthq_pkg::ModeQuery, 16'd0, 32'h0, 32'h8000_0000, 32'h8000_0000, 1'b1, 32'h7FFF_FFFF},
      '{hmthq_pkg::ModeWrite, 16'd65278, 32'h0000_0000, 32'h0, 32'h0, 1'b0, 32'h0},
      '{hmthq_pkg::ModeWrite, 16'd65534, 32'h1234_5678, 32'h0, 32'h0, 1'b0, 32'h0},
      '{hmthq_pkg::ModeWrite, 16'd65535, 32'h8000_0000, 32'h0, 32'h0, 1'b0, 32'h0},
      '{hmthq_pkg::ModeQuery, 16'd0, 32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 32'h8000_0000},
      '{hmthq_pkg::ModeWrite, 16'd254,   32'hFFFF_FFFF, 32'h0, 32'h0, 1'b0, 32'h0},
      '{hmthq_pkg::ModeWrite, 16'd255,   32'h0001_0000, 32'h0, 32'h0, 1'b0, 32'h0},
      '{hmthq_pkg::ModeWrite, 16'd511,   32'h0000_0000, 32'h0, 32'h0, 1'b0, 32'h0},
      '{hmthq_pkg::ModeQuery, 16'd0, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 32'h0001_0000},
      '{hmthq_pkg::ModeWrite, 16'd65024, 32'h7FFF_FFFF, 32'h0, 32'h0, 1'b0, 32'h0},
      '{hmthq_pkg::ModeWrite, 16'd65280, 32'hFFFF_0000, 32'h0, 32'h0, 1'b0, 32'h0},
      '{hmthq_pkg::ModeWrite, 16'd65281, 32'h8000_0000, 32'h0, 32'h0, 1'b0, 32'h0},
      '{hmthq_pkg::ModeQuery, 16'd0, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 32'hFFFF_0000},
      '{hmthq_pkg::ModeWrite, 16'd32639, 32'h0003_0000, 32'h0, 32'h0, 1'b0, 32'h0},
      '{hmthq_pkg::ModeWrite, 16'd32895, 32'h0003_0000, 32'h0, 32'h0, 1'b0, 32'h0},
      '{hmthq_pkg::ModeWrite, 16'd32896, 32'h0003_0000, 32'h0, 32'h0, 1'b0, 32'h0},
      '{hmthq_pkg::ModeQuery, 16'd0, 32'h0, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0003_0000},
      '{hmthq_pkg::ModeQuery, 16'd0, 32'h0, 32'h0000_4000, 32'h0000_4000, 1'b0, 32'h0},
      '{hmthq_pkg::ModeQuery, 16'd0, 32'h0, 32'hFFFF_C000, 32'h0000_2000, 1'b0, 32'h0},
      '{hmthq_pkg::ModeQuery, 16'd0, 32'h0, 32'h0000_6000, 32'hFFFF_8000, 1'b0, 32'h0}
    };
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[r]) begin
      if (dir_rows[r].mode == hmthq_pkg::ModeWrite)
        write_height(dir_rows[r].idx, dir_rows[r].val);
      else
        query_height(dir_rows[r].qx, dir_rows[r].qz, dir_rows[r].typed, dir_rows[r].result);
    end
    settle();

    run_phase(9'd2,   32'h0001_0000, 0, 1'b0);
    run_phase(9'd0,   32'hFFFF_FFFF, 1, 1'b0);
    run_phase(9'd1,   32'h0000_0000, 2, 1'b0);
    run_phase(9'd256, 32'h0000_0001, 3, 1'b0);
    run_phase(9'd511, 32'h0001_0000, 1, 1'b0);
    run_phase(9'd300, 32'h0080_0000, 2, 1'b0);
    run_phase(9'd17,  $urandom,      3, 1'b0);
    run_phase(9'd5,   32'h0001_0000, 0, 1'b1);
    run_phase(9'($urandom_range(2, 64)), $urandom_range(1, 32'h0010_0000), 3, 1'b0);
    run_phase(9'd200, 32'h0000_1000, 0, 1'b0);
    run_phase(9'd256, 32'h0001_0000, 2, 1'b0);

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/hmthq_pkg.sv
rtl/heightmap_triangle_height_query.sv
sim/testbench.sv
